>>> rtl/core/cct_pkg.sv
// Shared types, constants and helper functions of the component color transform.
package cct_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 18;
  localparam int COEF_FRAC_BITS_DEF = 14;
  localparam int CLAMP_WIDTH        = 18;
  localparam int APB_ADDR_W         = 5;
  localparam int APB_DATA_W         = 32;
  localparam longint MICRO          = 64'sd1000000;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RCT  = 2'd1,
    KIND_ICT  = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_KIND  = 3'd0,
    REG_DIR   = 3'd1,
    REG_SHIFT = 3'd2,
    REG_CMIN  = 3'd3,
    REG_CMAX  = 3'd4
  } reg_idx_t;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_INV = 1'b1;

  typedef struct packed {
    logic [1:0]                    kind;
    logic                          dir;
    logic [3:0]                    lshift;
    logic signed [CLAMP_WIDTH-1:0] cmin;
    logic signed [CLAMP_WIDTH-1:0] cmax;
  } cfg_t;

  // Width of a level-shifted sample: room for the sample minus an offset up to 2^15.
  function automatic int dat_w(input int sw);
    return ((sw > 16) ? sw : 16) + 1;
  endfunction

  // Width of a transformed component before offset, clamp and saturation.
  function automatic int int_w(input int sw);
    return dat_w(sw) + 2;
  endfunction

  // Fixed-point coefficient: nearest integer to micro/1e6 * 2^frac.
  function automatic longint coef_q(input longint micro, input int frac);
    return (micro * (64'sd1 <<< frac) + MICRO / 2) / MICRO;
  endfunction

endpackage

>>> rtl/core/cct_regs.sv
// APB configuration registers of the color transform.
module cct_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cct_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [cct_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [cct_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output cct_pkg::cfg_t                     cfg
);

  cct_pkg::cfg_t cfg_r;
  cct_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[cct_pkg::APB_ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        cct_pkg::REG_KIND:  cfg_nxt.kind   = pwdata[1:0];
        cct_pkg::REG_DIR:   cfg_nxt.dir    = pwdata[0];
        cct_pkg::REG_SHIFT: cfg_nxt.lshift = pwdata[3:0];
        cct_pkg::REG_CMIN:  cfg_nxt.cmin   = pwdata[cct_pkg::CLAMP_WIDTH-1:0];
        cct_pkg::REG_CMAX:  cfg_nxt.cmax   = pwdata[cct_pkg::CLAMP_WIDTH-1:0];
        default:            cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kind   <= cct_pkg::KIND_RCT;
      cfg_r.dir    <= cct_pkg::DIR_FWD;
      cfg_r.lshift <= 4'd7;
      cfg_r.cmin   <= '0;
      cfg_r.cmax   <= cct_pkg::CLAMP_WIDTH'(255);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      cct_pkg::REG_KIND:  prdata = cct_pkg::APB_DATA_W'(cfg_r.kind);
      cct_pkg::REG_DIR:   prdata = cct_pkg::APB_DATA_W'(cfg_r.dir);
      cct_pkg::REG_SHIFT: prdata = cct_pkg::APB_DATA_W'(cfg_r.lshift);
      cct_pkg::REG_CMIN:  prdata = cct_pkg::APB_DATA_W'(cfg_r.cmin);
      cct_pkg::REG_CMAX:  prdata = cct_pkg::APB_DATA_W'(cfg_r.cmax);
      default:            prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/cct_pre.sv
// Input stage: register the pixel and remove the DC offset in forward direction.
module cct_pre #(
  parameter int SAMPLE_WIDTH = cct_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             vld_in,
  input  logic signed [SAMPLE_WIDTH-1:0]                   c0,
  input  logic signed [SAMPLE_WIDTH-1:0]                   c1,
  input  logic signed [SAMPLE_WIDTH-1:0]                   c2,
  input  cct_pkg::cfg_t                                    cfg,
  output logic                                             vld_r,
  output logic signed [cct_pkg::dat_w(SAMPLE_WIDTH)-1:0]   d_r [3]
);

  localparam int DW = cct_pkg::dat_w(SAMPLE_WIDTH);

  logic signed [DW-1:0] off;
  logic signed [DW-1:0] d_nxt [3];

  // Offset is 2^lshift going forward, nothing going back.
  assign off = (cfg.dir == cct_pkg::DIR_FWD) ? (DW'(1) <<< cfg.lshift) : '0;

  always_comb begin
    d_nxt[0] = DW'(c0) - off;
    d_nxt[1] = DW'(c1) - off;
    d_nxt[2] = DW'(c2) - off;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

endmodule

>>> rtl/core/cct_mat.sv
// Matrix stages: ICT multiply, two-level sum and rounding, with the integer RCT alongside.
module cct_mat #(
  parameter int SAMPLE_WIDTH   = cct_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = cct_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             vld_in,
  input  logic signed [cct_pkg::dat_w(SAMPLE_WIDTH)-1:0]   d [3],
  input  cct_pkg::cfg_t                                    cfg,
  output logic                                             vld_r,
  output logic signed [cct_pkg::int_w(SAMPLE_WIDTH)-1:0]   res_r [3]
);

  localparam int DW = cct_pkg::dat_w(SAMPLE_WIDTH);
  localparam int IW = cct_pkg::int_w(SAMPLE_WIDTH);
  localparam int F  = COEF_FRAC_BITS;
  localparam int CW = F + 2;
  localparam int PW = DW + CW;

  localparam logic signed [CW-1:0] C_ONE  = CW'(64'sd1 <<< F);
  localparam logic signed [CW-1:0] C_YR   = CW'(cct_pkg::coef_q(64'sd299000, F));
  localparam logic signed [CW-1:0] C_YG   = CW'(cct_pkg::coef_q(64'sd587000, F));
  localparam logic signed [CW-1:0] C_YB   = CW'(cct_pkg::coef_q(64'sd114000, F));
  localparam logic signed [CW-1:0] C_UR   = CW'(-cct_pkg::coef_q(64'sd168750, F));
  localparam logic signed [CW-1:0] C_UG   = CW'(-cct_pkg::coef_q(64'sd331260, F));
  localparam logic signed [CW-1:0] C_HALF = CW'(cct_pkg::coef_q(64'sd500000, F));
  localparam logic signed [CW-1:0] C_VG   = CW'(-cct_pkg::coef_q(64'sd418690, F));
  localparam logic signed [CW-1:0] C_VB   = CW'(-cct_pkg::coef_q(64'sd81310, F));
  localparam logic signed [CW-1:0] C_RV   = CW'(cct_pkg::coef_q(64'sd1402000, F));
  localparam logic signed [CW-1:0] C_BU   = CW'(cct_pkg::coef_q(64'sd1772000, F));
  localparam logic signed [CW-1:0] C_GU   = CW'(-cct_pkg::coef_q(64'sd344136, F));
  localparam logic signed [CW-1:0] C_GV   = CW'(-cct_pkg::coef_q(64'sd714136, F));

  // Rows are output components, columns are input components.
  localparam logic signed [CW-1:0] FWD_M [3][3] = '{
    '{C_YR,   C_YG, C_YB},
    '{C_UR,   C_UG, C_HALF},
    '{C_HALF, C_VG, C_VB}
  };
  localparam logic signed [CW-1:0] INV_M [3][3] = '{
    '{C_ONE, '0,   C_RV},
    '{C_ONE, C_GU, C_GV},
    '{C_ONE, C_BU, '0}
  };

  localparam logic signed [PW:0] RND = (PW+1)'(1) <<< (F - 1);

  logic signed [PW-1:0]   p_nxt [3][3];
  logic signed [PW-1:0]   p_r   [3][3];
  logic signed [IW-1:0]   lin_nxt [3];
  logic signed [IW-1:0]   lin2_r  [3];
  logic signed [IW-1:0]   lin3_r  [3];
  logic signed [PW:0]     s01_r   [3];
  logic signed [PW:0]     s2_r    [3];
  logic signed [PW+1:0]   acc     [3];
  logic signed [IW-1:0]   res_nxt [3];
  logic signed [IW-1:0]   rsum;
  logic signed [IW-1:0]   gi;
  logic                   v2_r;
  logic                   v3_r;

  // Stage 2: nine products, integer RCT on the side.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_nxt[i][j] = PW'(d[j]) *
                      PW'((cfg.dir == cct_pkg::DIR_INV) ? INV_M[i][j] : FWD_M[i][j]);
      end
    end
  end

  always_comb begin
    rsum = '0;
    gi   = '0;
    if (cfg.kind == cct_pkg::KIND_RCT) begin
      if (cfg.dir == cct_pkg::DIR_FWD) begin
        rsum       = IW'(d[0]) + (IW'(d[1]) <<< 1) + IW'(d[2]);
        lin_nxt[0] = rsum >>> 2;
        lin_nxt[1] = IW'(d[2]) - IW'(d[1]);
        lin_nxt[2] = IW'(d[0]) - IW'(d[1]);
      end else begin
        rsum       = IW'(d[1]) + IW'(d[2]);
        gi         = IW'(d[0]) - (rsum >>> 2);
        lin_nxt[0] = IW'(d[2]) + gi;
        lin_nxt[1] = gi;
        lin_nxt[2] = IW'(d[1]) + gi;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        lin_nxt[i] = IW'(d[i]);
      end
    end
  end

  // Stage 4: final add, round to nearest and pick the ICT or the integer path.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = (PW+2)'(s01_r[i]) + (PW+2)'(s2_r[i]);
      if (cfg.kind == cct_pkg::KIND_ICT) begin
        res_nxt[i] = IW'(acc[i] >>> F);
      end else begin
        res_nxt[i] = lin3_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      v2_r  <= vld_in;
      v3_r  <= v2_r;
      vld_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    lin2_r <= lin_nxt;
    for (int i = 0; i < 3; i++) begin
      s01_r[i] <= (PW+1)'(p_r[i][0]) + (PW+1)'(p_r[i][1]);
      s2_r[i]  <= (PW+1)'(p_r[i][2]) + RND;
    end
    lin3_r <= lin2_r;
    res_r  <= res_nxt;
  end

endmodule

>>> rtl/core/cct_post.sv
// Output stage: in inverse direction add the DC offset back and clamp; saturate in both directions.
module cct_post #(
  parameter int SAMPLE_WIDTH = cct_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             vld_in,
  input  logic signed [cct_pkg::int_w(SAMPLE_WIDTH)-1:0]   res [3],
  input  cct_pkg::cfg_t                                    cfg,
  output logic                                             vld_r,
  output logic signed [SAMPLE_WIDTH-1:0]                   out_r [3]
);

  localparam int IW = cct_pkg::int_w(SAMPLE_WIDTH);
  localparam int FW = IW + 1;

  localparam logic signed [FW-1:0] SAT_HI = FW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [FW-1:0] SAT_LO = -SAT_HI - FW'(1);

  logic signed [FW-1:0]           off;
  logic signed [FW-1:0]           cmin;
  logic signed [FW-1:0]           cmax;
  logic signed [FW-1:0]           v     [3];
  logic signed [FW-1:0]           cl    [3];
  logic signed [SAMPLE_WIDTH-1:0] out_nxt [3];

  assign off  = FW'(1) <<< cfg.lshift;
  assign cmin = FW'(cfg.cmin);
  assign cmax = FW'(cfg.cmax);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cfg.dir == cct_pkg::DIR_INV) begin
        v[i] = FW'(res[i]) + off;
        priority if (v[i] < cmin) begin
          cl[i] = cmin;
        end else if (v[i] > cmax) begin
          cl[i] = cmax;
        end else begin
          cl[i] = v[i];
        end
      end else begin
        v[i]  = FW'(res[i]);
        cl[i] = v[i];
      end
      priority if (cl[i] < SAT_LO) begin
        out_nxt[i] = SAT_LO[SAMPLE_WIDTH-1:0];
      end else if (cl[i] > SAT_HI) begin
        out_nxt[i] = SAT_HI[SAMPLE_WIDTH-1:0];
      end else begin
        out_nxt[i] = cl[i][SAMPLE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

>>> rtl/core/component_color_transform_unit.sv
// Top level of the component color transform: level shift, RCT/ICT and clamp pipeline.
//
// Usage:
//   Input channel: drive in_c0/in_c1/in_c2 and raise start; the item is taken at
//   every rising edge with start high and busy low. busy stays low, so one pixel
//   can enter in every clock cycle.
//   Result channel: out_valid is high for exactly one cycle with out_c0..out_c2;
//   the receiver takes the item at the end of that cycle and cannot stall.
//   Pipeline: an accepted item passes five register stages (offset, multiply,
//   partial sums, final sum and rounding, offset/clamp/saturate) to the outputs.
//   Throughput: one item per cycle.
//   The three products of each ICT row and the wide adds of their sum set the
//   stage split; the RCT runs beside the multipliers and is delayed to match.
//   Configuration: APB port, register i at byte address 4*i (kind, direction,
//   level shift, clamp min, clamp max); pready is always high. Write it only
//   while no item is in flight.
//   Reset: rst_n (synchronous) clears all valid bits and loads the registers
//   with RCT, forward, level shift 7, clamp range 0..255.
module component_color_transform_unit #(
  parameter int SAMPLE_WIDTH   = cct_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = cct_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              start,
  output logic                              busy,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_c0,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_c1,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_c2,
  // Result channel
  output logic                              out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]    out_c0,
  output logic signed [SAMPLE_WIDTH-1:0]    out_c1,
  output logic signed [SAMPLE_WIDTH-1:0]    out_c2,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cct_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [cct_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [cct_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int DW = cct_pkg::dat_w(SAMPLE_WIDTH);
  localparam int IW = cct_pkg::int_w(SAMPLE_WIDTH);

  cct_pkg::cfg_t                  cfg;
  logic                           in_vld;
  logic                           v1;
  logic                           v4;
  logic signed [DW-1:0]           d1  [3];
  logic signed [IW-1:0]           res4 [3];
  logic signed [SAMPLE_WIDTH-1:0] res5 [3];

  // The pipeline never stalls, so every item offered is taken.
  assign busy   = 1'b0;
  assign in_vld = start & ~busy;

  cct_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage 1: register the pixel, subtract the DC offset going forward.
  cct_pre #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_pre (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (in_vld),
    .c0     (in_c0),
    .c1     (in_c1),
    .c2     (in_c2),
    .cfg    (cfg),
    .vld_r  (v1),
    .d_r    (d1)
  );

  // Stages 2 to 4: products, sums and rounding; RCT carried alongside.
  cct_mat #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mat (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (v1),
    .d      (d1),
    .cfg    (cfg),
    .vld_r  (v4),
    .res_r  (res4)
  );

  // Stage 5: offset back and clamp going inverse, saturate; this is the output register.
  cct_post #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_post (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (v4),
    .res    (res4),
    .cfg    (cfg),
    .vld_r  (out_valid),
    .out_r  (res5)
  );

  assign out_c0 = res5[0];
  assign out_c1 = res5[1];
  assign out_c2 = res5[2];

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the component color transform unit: random pixels, configs, gaps.
module tb_top;
  import cct_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int FRAC = COEF_FRAC_BITS_DEF;
  localparam longint SMAX = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint SMIN = -(64'sd1 <<< (SW - 1));
  // Five register stages from accepted item to result; leave some slack on top.
  localparam int LATENCY = 5;
  localparam int SETTLE_CYCLES = LATENCY + 4;
  localparam int LOST_WAIT = 200;
  localparam int RANDOM_ITEMS = 1700;
  localparam longint RUN_LIMIT = 64'd400000 * 64'd12;

  // Round a coefficient given in millionths to the fixed-point grid, ties away from zero.
  function automatic longint coef_fixed(input longint ppm);
    return (ppm * (64'sd1 <<< FRAC) + 64'sd500000) / 64'sd1000000;
  endfunction

  // Forward ICT rows (Y, U, V); signs are applied in the predictor.
  localparam longint Y_R = coef_fixed(299000);
  localparam longint Y_G = coef_fixed(587000);
  localparam longint Y_B = coef_fixed(114000);
  localparam longint U_R = coef_fixed(168750);
  localparam longint U_G = coef_fixed(331260);
  localparam longint U_B = coef_fixed(500000);
  localparam longint V_R = coef_fixed(500000);
  localparam longint V_G = coef_fixed(418690);
  localparam longint V_B = coef_fixed(81310);
  // Inverse ICT weights.
  localparam longint R_V = coef_fixed(1402000);
  localparam longint B_U = coef_fixed(1772000);
  localparam longint G_U = coef_fixed(344136);
  localparam longint G_V = coef_fixed(714136);

  typedef struct packed {
    logic signed [SW-1:0] c0;
    logic signed [SW-1:0] c1;
    logic signed [SW-1:0] c2;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic start = 1'b0;
  logic busy;
  logic signed [SW-1:0] in_c0 = '0;
  logic signed [SW-1:0] in_c1 = '0;
  logic signed [SW-1:0] in_c2 = '0;

  logic out_valid;
  logic signed [SW-1:0] out_c0;
  logic signed [SW-1:0] out_c1;
  logic signed [SW-1:0] out_c2;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // Shadow of the block's registers, loaded with the reset values.
  kind_t xf_kind = KIND_RCT;
  logic xf_dir = DIR_FWD;
  int xf_shift = 7;
  longint clamp_lo = 0;
  longint clamp_hi = 255;

  pixel_t pending_pixels[$];
  pixel_t expected_pixels[$];
  int gap_left = 0;
  bit gaps_on = 1'b0;
  int fail_count = 0;

  component_color_transform_unit #(
    .SAMPLE_WIDTH  (SW),
    .COEF_FRAC_BITS(FRAC)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_c0    (in_c0),
    .in_c1    (in_c1),
    .in_c2    (in_c2),
    .out_valid(out_valid),
    .out_c0   (out_c0),
    .out_c1   (out_c1),
    .out_c2   (out_c2),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pixel arithmetic
  // ---------------------------------------------------------------------------

  function automatic longint clip_sample(input longint v);
    if (v < SMIN) return SMIN;
    if (v > SMAX) return SMAX;
    return v;
  endfunction

  // Add half an LSB, then floor-shift: round to nearest, ties toward +infinity.
  function automatic longint round_fixed(input longint acc);
    return (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  // Restore the DC offset, clamp (lower bound wins when the bounds cross), saturate.
  function automatic longint restore_sample(input longint v, input longint off);
    longint s;
    s = v + off;
    if (s < clamp_lo) s = clamp_lo;
    else if (s > clamp_hi) s = clamp_hi;
    return clip_sample(s);
  endfunction

  // Expected result of one pixel under the current shadow configuration.
  function automatic pixel_t transform_pixel(input pixel_t px);
    longint a, b, c, off, r, g, bl, ys, o0, o1, o2;
    pixel_t res;
    a = $signed(px.c0);
    b = $signed(px.c1);
    c = $signed(px.c2);
    off = 64'sd1 <<< xf_shift;
    if (xf_dir == DIR_FWD) begin
      r = a - off;
      g = b - off;
      bl = c - off;
      case (xf_kind)
        KIND_RCT: begin
          o0 = (r + 2 * g + bl) >>> 2;
          o1 = bl - g;
          o2 = r - g;
        end
        KIND_ICT: begin
          o0 = round_fixed(Y_R * r + Y_G * g + Y_B * bl);
          o1 = round_fixed(-U_R * r - U_G * g + U_B * bl);
          o2 = round_fixed(V_R * r - V_G * g - V_B * bl);
        end
        default: begin
          // Level shift only; the reserved kind behaves the same way.
          o0 = r;
          o1 = g;
          o2 = bl;
        end
      endcase
      o0 = clip_sample(o0);
      o1 = clip_sample(o1);
      o2 = clip_sample(o2);
    end else begin
      case (xf_kind)
        KIND_RCT: begin
          g = a - ((b + c) >>> 2);
          r = c + g;
          bl = b + g;
        end
        KIND_ICT: begin
          ys = a <<< FRAC;
          r = round_fixed(ys + R_V * c);
          bl = round_fixed(ys + B_U * b);
          g = round_fixed(ys - G_U * b - G_V * c);
        end
        default: begin
          r = a;
          g = b;
          bl = c;
        end
      endcase
      o0 = restore_sample(r, off);
      o1 = restore_sample(g, off);
      o2 = restore_sample(bl, off);
    end
    res.c0 = SW'(o0);
    res.c1 = SW'(o1);
    res.c2 = SW'(o2);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pixel_t pix(input longint x, input longint y, input longint z);
    pixel_t p;
    p.c0 = SW'(x);
    p.c1 = SW'(y);
    p.c2 = SW'(z);
    return p;
  endfunction

  // Any value of the field, every bit free.
  function automatic longint any_sample();
    logic signed [SW-1:0] v;
    v = SW'($urandom());
    return v;
  endfunction

  // Draw one component: free, natural image range, or an extreme.
  function automatic longint pick_sample(input int mode);
    longint span;
    span = 64'sd1 <<< xf_shift;
    if (mode < 4) return any_sample();
    if (mode < 8) begin
      // Forward takes unsigned samples of the shift's bit depth, inverse centered ones.
      return longint'($urandom_range(0, 32'(2 * span - 1))) - (xf_dir ? span : 0);
    end
    case ($urandom_range(0, 4))
      0: return SMIN;
      1: return SMAX;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic pixel_t make_pixel();
    int mode;
    pixel_t p;
    mode = $urandom_range(0, 9);
    // Mode nine mixes kinds of values across the three components.
    p.c0 = SW'(pick_sample((mode == 9) ? $urandom_range(0, 8) : mode));
    p.c1 = SW'(pick_sample((mode == 9) ? $urandom_range(0, 8) : mode));
    p.c2 = SW'(pick_sample((mode == 9) ? $urandom_range(0, 8) : mode));
    return p;
  endfunction

  // Mostly back to back, often a short pause, now and then a long one.
  function automatic int idle_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------

  // Setup cycle, then access; the register takes the value at the edge with pready high.
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KIND: xf_kind = kind_t'(value[1:0]);
      REG_DIR: xf_dir = value[0];
      REG_SHIFT: xf_shift = int'(value[3:0]);
      REG_CMIN: clamp_lo = longint'($signed(value[CLAMP_WIDTH-1:0]));
      REG_CMAX: clamp_hi = longint'($signed(value[CLAMP_WIDTH-1:0]));
      default: ;
    endcase
  endtask

  task automatic load_setup(input kind_t kind, input logic dir, input int shift,
                            input longint lo, input longint hi);
    write_reg(REG_KIND, 32'(kind));
    write_reg(REG_DIR, 32'(dir));
    write_reg(REG_SHIFT, 32'(shift));
    write_reg(REG_CMIN, 32'(lo));
    write_reg(REG_CMAX, 32'(hi));
  endtask

  // Wait for the queued pixels to go in and their results to come out, then let the
  // pipeline settle so the next register write finds it empty. The input side is
  // checked at the falling edge, after the driver has updated queue and start.
  task automatic drain_results();
    int waited;
    waited = 0;
    while (pending_pixels.size() > 0 || start) @(negedge clk);
    while (expected_pixels.size() > 0 && waited < LOST_WAIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_pixels.size() > 0) begin
      fail_count++;
      $display("%0t: %0d result(s) never arrived", $time, expected_pixels.size());
      expected_pixels.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: feed pixels from the pending queue, predict each one as it is taken
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    pixel_t taken;
    pixel_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      // Record the prediction for the item taken at this edge.
      if (start && !busy) begin
        taken.c0 = in_c0;
        taken.c1 = in_c1;
        taken.c2 = in_c2;
        expected_pixels.push_back(transform_pixel(taken));
      end
      // Hold the current item while busy; otherwise idle or advance.
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_pixels.size() > 0) begin
          nxt = pending_pixels.pop_front();
          in_c0 <= nxt.c0;
          in_c1 <= nxt.c1;
          in_c2 <= nxt.c2;
          start <= 1'b1;
          gap_left <= idle_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result is matched against the oldest prediction
  // ---------------------------------------------------------------------------

  task automatic check_component(input string label, input logic signed [SW-1:0] want,
                                 input logic signed [SW-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                 $time, out_c0, out_c1, out_c2);
      end else begin
        want = expected_pixels.pop_front();
        check_component("out_c0", want.c0, out_c0);
        check_component("out_c1", want.c1, out_c1);
        check_component("out_c2", want.c2, out_c2);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed corners, then random phases with fresh settings
  // ---------------------------------------------------------------------------

  initial begin
    int k;
    int d;
    int shift;
    int count;
    int random_items;
    longint lo;
    longint hi;
    random_items = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: forward RCT, shift 7. Drive zero and the field extremes.
    pending_pixels.push_back(pix(0, 0, 0));
    pending_pixels.push_back(pix(SMAX, SMAX, SMAX));
    pending_pixels.push_back(pix(SMIN, SMIN, SMIN));
    pending_pixels.push_back(pix(SMAX, SMIN, SMAX));
    drain_results();

    // Every kind, reserved one included, in both directions; alternate shift and
    // clamp extremes so saturation and clamping both show up.
    gaps_on = 1'b1;
    for (k = 0; k < 4; k++) begin
      for (d = 0; d < 2; d++) begin
        shift = ((k + d) % 2 == 1) ? 15 : 0;
        lo = (k % 2 == 1) ? SMIN : 0;
        hi = (k % 2 == 1) ? SMAX : 255;
        load_setup(kind_t'(2'(k)), 1'(d), shift, lo, hi);
        pending_pixels.push_back(pix(SMAX, SMIN, SMAX));
        pending_pixels.push_back(pix(SMIN, SMAX, 1));
        drain_results();
      end
    end

    // Crossed clamp bounds: low values go to the lower bound, high ones to the upper.
    load_setup(KIND_NONE, DIR_INV, 0, 200, 100);
    pending_pixels.push_back(pix(50, 150, 250));
    drain_results();

    // Random phases: new settings, then a burst of pixels drawn for those settings.
    while (random_items < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      shift = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 15 : 0)
                                          : $urandom_range(0, 15);
      case ($urandom_range(0, 3))
        0: begin
          lo = 0;
          hi = (64'sd1 <<< (shift + 1)) - 1;
        end
        1: begin
          lo = SMIN;
          hi = SMAX;
        end
        2: begin
          lo = $urandom_range(0, 1000);
          hi = lo - $urandom_range(1, 500);
        end
        default: begin
          lo = any_sample();
          hi = any_sample();
        end
      endcase
      load_setup(kind_t'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)), shift, lo, hi);
      count = $urandom_range(10, 70);
      repeat (count) pending_pixels.push_back(make_pixel());
      random_items += count;
      drain_results();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT);
    $display("%0t: run limit reached", $time);
    $display("Regression FAIL");
    $finish;
  end

endmodule
